FILE: src/nos_pkg.sv
// ----------------------------------------------------------------------------
// nos_pkg: shared definitions for the nearest onset snap block
// Operation codes, status codes and default sizes.
// ----------------------------------------------------------------------------
package nos_pkg;

   localparam int unsigned WORD_W              = 32;
   localparam int unsigned ONSET_DEPTH_DEFAULT = 256;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [1:0]        op_type;
   typedef logic [1:0]        status_type;

   // operation codes
   localparam op_type OP_CLEAR  = 2'd0;
   localparam op_type OP_APPEND = 2'd1;
   localparam op_type OP_QUERY  = 2'd2;

   // status codes
   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL  = 2'd2;
   localparam status_type ST_ORDER = 2'd3;

endpackage

FILE: src/nearest_onset_snap_top.sv
// ----------------------------------------------------------------------------
// nearest_onset_snap_top: snap a play position to the nearest stored onset
// Ascending onset table with clear, append and binary-search query.
// ----------------------------------------------------------------------------
// Clear, append and the unused op code take one cycle: the result strobes on
// the cycle after start, and busy stays low so the next beat can follow at
// once. A query on a filled table keeps busy high while one shared compare
// walks a binary search through the table memory, one probe per cycle, plus
// two more reads for the two neighbors when the position falls between
// onsets. The result is on rsp_* for exactly one cycle marked by rsp_valid;
// the receiver cannot stall it. No clearing pass is needed after reset.
module nearest_onset_snap_top #(
   parameter int unsigned ONSET_DEPTH = nos_pkg::ONSET_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  nos_pkg::op_type        req_op,
   input  nos_pkg::word_type      req_value,
   output logic                   rsp_valid,
   output nos_pkg::word_type      rsp_snapped,
   output nos_pkg::status_type    rsp_status
);
   import nos_pkg::*;

   localparam int unsigned IDX_W = $clog2(ONSET_DEPTH);
   localparam int unsigned CNT_W = $clog2(ONSET_DEPTH + 1);

   // sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_STEP = 2'd1;
   localparam logic [1:0] S_PREV = 2'd2;
   localparam logic [1:0] S_NEXT = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [CNT_W-1:0] mid_ff, mid_in;
   word_type         pos_ff, pos_in;
   word_type         first_ff, first_in;
   word_type         last_ff, last_in;
   word_type         prev_ff, prev_in;
   logic             rsp_valid_ff, rsp_valid_in;
   word_type         rsp_snapped_ff, rsp_snapped_in;
   status_type       rsp_status_ff, rsp_status_in;

   logic             accept;
   logic             wr_en;
   logic [CNT_W-1:0] rd_addr;
   word_type         rd_data;

   // search step terms
   logic             probe_gt;
   logic [CNT_W-1:0] lo_n, hi_n, mid_n;
   word_type         d0, d1;

   assign accept = start && !busy;

   nos_table #(.DEPTH(ONSET_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_value),
      .rd_addr (rd_addr[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // shared compare: narrow the window around the probe just read
   always_comb begin
      probe_gt = rd_data > pos_ff;
      lo_n     = probe_gt ? lo_ff : mid_ff + CNT_W'(1);
      hi_n     = probe_gt ? mid_ff : hi_ff;
      mid_n    = lo_n + ((hi_n - lo_n) >> 1);
      d0       = pos_ff - prev_ff;
      d1       = rd_data - pos_ff;
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      mid_in         = mid_ff;
      pos_in         = pos_ff;
      first_in       = first_ff;
      last_in        = last_ff;
      prev_in        = prev_ff;
      rsp_valid_in   = 1'b0;
      rsp_snapped_in = rsp_snapped_ff;
      rsp_status_in  = rsp_status_ff;
      wr_en          = 1'b0;
      rd_addr        = mid_ff;

      case (state_ff)
         S_IDLE: begin
            rd_addr = count_ff >> 1;
            if (accept) begin
               rsp_valid_in   = 1'b1;
               rsp_snapped_in = '0;
               rsp_status_in  = ST_OK;
               case (req_op)
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  OP_APPEND: begin
                     if (count_ff >= CNT_W'(ONSET_DEPTH)) begin
                        rsp_status_in = ST_FULL;
                     end else if (count_ff != '0 && req_value < last_ff) begin
                        rsp_status_in = ST_ORDER;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                        last_in  = req_value;
                        if (count_ff == '0) begin
                           first_in = req_value;
                        end
                     end
                  end
                  OP_QUERY: begin
                     if (count_ff == '0) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        // first probe goes out now; result comes later
                        rsp_valid_in = 1'b0;
                        pos_in       = req_value;
                        lo_in        = '0;
                        hi_in        = count_ff;
                        mid_in       = count_ff >> 1;
                        state_in     = S_STEP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_STEP: begin
            lo_in = lo_n;
            hi_in = hi_n;
            if (lo_n < hi_n) begin
               rd_addr = mid_n;
               mid_in  = mid_n;
            end else if (lo_n == count_ff) begin
               rsp_valid_in   = 1'b1;
               rsp_snapped_in = last_ff;
               rsp_status_in  = ST_OK;
               state_in       = S_IDLE;
            end else if (lo_n == '0) begin
               rsp_valid_in   = 1'b1;
               rsp_snapped_in = first_ff;
               rsp_status_in  = ST_OK;
               state_in       = S_IDLE;
            end else begin
               rd_addr  = lo_n - CNT_W'(1);
               state_in = S_PREV;
            end
         end
         S_PREV: begin
            // lower neighbor arrives; fetch the upper one
            prev_in  = rd_data;
            rd_addr  = lo_ff;
            state_in = S_NEXT;
         end
         S_NEXT: begin
            // tie goes to the later onset
            rsp_valid_in   = 1'b1;
            rsp_snapped_in = (d0 < d1) ? prev_ff : rd_data;
            rsp_status_in  = ST_OK;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      mid_ff         <= mid_in;
      pos_ff         <= pos_in;
      first_ff       <= first_in;
      last_ff        <= last_in;
      prev_ff        <= prev_in;
      rsp_snapped_ff <= rsp_snapped_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign busy        = state_ff != S_IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_snapped = rsp_snapped_ff;
   assign rsp_status  = rsp_status_ff;

   // a result only shows once the sequencer is back home
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while sequencer busy");

   // the fill count never passes the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ONSET_DEPTH))
      else $error("onset count beyond table depth");

   // anything but a query on a filled table answers in the next cycle
   a_quick_rsp: assert property (@(posedge clock) disable iff (reset)
      accept && !(req_op == OP_QUERY && count_ff != '0) |=> rsp_valid)
      else $error("missing single-cycle result");

   // the search window stays inside the filled part of the table
   a_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_STEP |-> lo_ff <= hi_ff && hi_ff <= count_ff && mid_ff < count_ff)
      else $error("search window out of range");

endmodule

FILE: src/nos_table.sv
// ----------------------------------------------------------------------------
// nos_table: onset position memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module nos_table #(
   parameter int unsigned DEPTH = nos_pkg::ONSET_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  nos_pkg::word_type        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output nos_pkg::word_type        rd_data
);
   import nos_pkg::*;

   word_type mem_ff [DEPTH];
   word_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered: data follows in the cycle after the address
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: verif/nearest_onset_snap_top_test.sv
// ----------------------------------------------------------------------------
// nearest_onset_snap_top_test: self-checking bench for the onset snap block
// Drives clear, append and query beats and checks each result against a
// behavioral copy of the onset table or a typed-in expectation. A short directed
// table comes first, then random sequences: a clear, ascending appends, then
// queries aimed at onsets, midpoints and the ends, at several sender idle rates.
// ----------------------------------------------------------------------------
module nearest_onset_snap_top_test;
   import nos_pkg::*;

   localparam int unsigned DEPTH       = ONSET_DEPTH_DEFAULT;
   localparam int          CYCLE_LIMIT = 600000;
   localparam int          PHASE_BEATS = 200;
   localparam op_type      OP_UNUSED   = 2'd3;

   typedef struct {
      word_type   snapped;
      status_type status;
   } snap_result_type;

   typedef struct packed {
      op_type     op;
      word_type   value;
      logic       has_exp;
      word_type   exp_snapped;
      status_type exp_status;
   } stim_row_type;

   // directed beats; expectations typed in only where obvious
   localparam int NUM_ROWS = 22;
   stim_row_type directed_rows [0:NUM_ROWS-1] = '{
      '{OP_QUERY,  32'h0000_0000, 1'b1, 32'h0,   ST_EMPTY},  // query, empty table
      '{OP_UNUSED, 32'hFFFF_FFFF, 1'b1, 32'h0,   ST_OK},     // unused op code
      '{OP_APPEND, 32'h0000_0000, 1'b1, 32'h0,   ST_OK},
      '{OP_APPEND, 32'h0000_0064, 1'b1, 32'h0,   ST_OK},
      '{OP_APPEND, 32'h0000_0064, 1'b1, 32'h0,   ST_OK},     // equal to last
      '{OP_APPEND, 32'h0000_0032, 1'b1, 32'h0,   ST_ORDER},  // below last
      '{OP_APPEND, 32'h0000_012C, 1'b1, 32'h0,   ST_OK},
      '{OP_QUERY,  32'h0000_0000, 1'b0, 32'h0,   ST_OK},
      '{OP_QUERY,  32'h0000_00C8, 1'b0, 32'h0,   ST_OK},     // tie, later wins
      '{OP_QUERY,  32'h0000_00C7, 1'b0, 32'h0,   ST_OK},
      '{OP_QUERY,  32'h0000_00C9, 1'b0, 32'h0,   ST_OK},
      '{OP_QUERY,  32'hFFFF_FFFF, 1'b1, 32'h12C, ST_OK},     // past last onset
      '{OP_QUERY,  32'h0000_0064, 1'b0, 32'h0,   ST_OK},
      '{OP_APPEND, 32'hFFFF_FFFF, 1'b1, 32'h0,   ST_OK},
      '{OP_QUERY,  32'hFFFF_FFFE, 1'b0, 32'h0,   ST_OK},
      '{OP_QUERY,  32'h8000_0096, 1'b0, 32'h0,   ST_OK},
      '{OP_CLEAR,  32'hFFFF_FFFF, 1'b1, 32'h0,   ST_OK},
      '{OP_QUERY,  32'h0000_0005, 1'b1, 32'h0,   ST_EMPTY},
      '{OP_APPEND, 32'h0000_03E8, 1'b1, 32'h0,   ST_OK},
      '{OP_QUERY,  32'h0000_0000, 1'b1, 32'h3E8, ST_OK},     // below first onset
      '{OP_QUERY,  32'hFFFF_FFFF, 1'b1, 32'h3E8, ST_OK},
      '{OP_APPEND, 32'h0000_03E7, 1'b1, 32'h0,   ST_ORDER}
   };

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       start     = 1'b0;
   op_type     req_op    = OP_CLEAR;
   word_type   req_value = '0;
   logic       busy;
   logic       rsp_valid;
   word_type   rsp_snapped;
   status_type rsp_status;

   // behavioral copy of the onset table
   word_type        onset_mem [0:DEPTH-1];
   int unsigned     onset_cnt = 0;
   snap_result_type pending_snaps [$];
   int              mismatch_cnt = 0;
   int              cycle_cnt = 0;
   int              beats_sent = 0;
   int              idle_pct = 0;

   nearest_onset_snap_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_op      (req_op),
      .req_value   (req_value),
      .rsp_valid   (rsp_valid),
      .rsp_snapped (rsp_snapped),
      .rsp_status  (rsp_status)
   );

   always #10 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("nearest_onset_snap_top_test failed");
         $finish;
      end
   end

   // apply one beat to the onset table copy and return its result
   function automatic snap_result_type apply_beat(op_type op, word_type value);
      snap_result_type res;
      int unsigned     idx;
      word_type        prev;
      word_type        next;
      res.snapped = '0;
      res.status  = ST_OK;
      case (op)
         OP_CLEAR: begin
            onset_cnt = 0;
         end
         OP_APPEND: begin
            if (onset_cnt >= DEPTH) begin
               res.status = ST_FULL;
            end else if (onset_cnt > 0 && value < onset_mem[onset_cnt-1]) begin
               res.status = ST_ORDER;
            end else begin
               onset_mem[onset_cnt] = value;
               onset_cnt++;
            end
         end
         OP_QUERY: begin
            if (onset_cnt == 0) begin
               res.status = ST_EMPTY;
            end else begin
               // first onset strictly above the position
               idx = 0;
               while (idx < onset_cnt && onset_mem[idx] <= value) idx++;
               if (idx == onset_cnt) begin
                  res.snapped = onset_mem[onset_cnt-1];
               end else if (idx == 0) begin
                  res.snapped = onset_mem[0];
               end else begin
                  prev = onset_mem[idx-1];
                  next = onset_mem[idx];
                  res.snapped = ((value - prev) < (next - value)) ? prev : next;
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // drive one beat, wait for it to be taken, then queue its result
   task automatic send_beat(input op_type op, input word_type value,
                            input logic has_exp, input word_type exp_snapped,
                            input status_type exp_status);
      snap_result_type predicted;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start     <= 1'b1;
      req_op    <= op;
      req_value <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = apply_beat(op, value);
      if (has_exp) begin
         predicted.snapped = exp_snapped;
         predicted.status  = exp_status;
      end
      pending_snaps = {pending_snaps, predicted};
      beats_sent++;
   endtask

   task automatic send(input op_type op, input word_type value);
      send_beat(op, value, 1'b0, '0, ST_OK);
   endtask

   // random sequences: clear, ascending appends, aimed queries, some noise
   task automatic run_phase(input int pct, input logic with_fill);
      int          phase_end;
      int unsigned num_appends;
      int unsigned num_queries;
      int unsigned mode;
      int unsigned pick;
      logic [32:0] wide;
      word_type    pos;
      logic        filled;
      idle_pct  = pct;
      phase_end = beats_sent + PHASE_BEATS;
      filled    = 1'b0;
      while (beats_sent < phase_end) begin
         if ($urandom_range(99) < 8) begin
            // noise beat, any op code
            send(op_type'($urandom_range(3)), $urandom);
         end else begin
            send(OP_CLEAR, $urandom);
            if (with_fill && !filled) begin
               num_appends = DEPTH + 3;
               mode        = 2;
               filled      = 1'b1;
            end else begin
               num_appends = ($urandom_range(9) == 0) ? $urandom_range(13, 60)
                                                      : $urandom_range(1, 12);
               mode        = $urandom_range(1);
            end
            for (int i = 0; i < num_appends; i++) begin
               if (onset_cnt > 0 && onset_mem[onset_cnt-1] > 0
                   && $urandom_range(9) == 0) begin
                  // out-of-order append
                  send(OP_APPEND, $urandom_range(0, onset_mem[onset_cnt-1] - 1));
               end else begin
                  if (onset_cnt == 0) begin
                     wide = (mode == 0) ? 33'($urandom_range(50))
                                        : 33'($urandom >> $urandom_range(31));
                  end else begin
                     case (mode)
                        0:       wide = 33'($urandom_range(3));
                        1:       wide = 33'($urandom >> $urandom_range(31));
                        default: wide = 33'($urandom_range(16'hFFFF));
                     endcase
                     wide = wide + onset_mem[onset_cnt-1];
                  end
                  send(OP_APPEND, wide[32] ? 32'hFFFF_FFFF : wide[31:0]);
               end
            end
            num_queries = $urandom_range(2, (num_appends > 20) ? 40 : 2*num_appends + 4);
            for (int i = 0; i < num_queries; i++) begin
               pick = (onset_cnt > 0) ? $urandom_range(onset_cnt - 1) : 0;
               case ((onset_cnt > 0) ? $urandom_range(5) : 0)
                  0: pos = $urandom;
                  1: pos = onset_mem[pick] + word_type'($urandom_range(6)) - 32'd3;
                  2: begin
                     // near the midpoint of neighbors; an exact tie is possible when the gap is even
                     if (pick + 1 < onset_cnt) begin
                        wide = {1'b0, onset_mem[pick]} + {1'b0, onset_mem[pick+1]};
                        pos  = wide[32:1] + word_type'($urandom_range(2)) - 32'd1;
                     end else begin
                        pos = onset_mem[pick];
                     end
                  end
                  3: pos = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
                  4: pos = onset_mem[pick];
                  default: begin
                     if (pick + 1 < onset_cnt)
                        pos = $urandom_range(onset_mem[pick+1], onset_mem[pick]);
                     else
                        pos = onset_mem[pick] + $urandom_range(1000);
                  end
               endcase
               send(OP_QUERY, pos);
            end
         end
      end
   endtask

   // result checker: every strobe must match the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_snaps.size() == 0) begin
            $error("unexpected result: snapped %0h status %0d", rsp_snapped, rsp_status);
            mismatch_cnt++;
         end else begin
            if (rsp_snapped !== pending_snaps[0].snapped) begin
               $error("snapped: expected %0h, got %0h",
                      pending_snaps[0].snapped, rsp_snapped);
               mismatch_cnt++;
            end
            if (rsp_status !== pending_snaps[0].status) begin
               $error("status: expected %0d, got %0d",
                      pending_snaps[0].status, rsp_status);
               mismatch_cnt++;
            end
            void'(pending_snaps.pop_front());
         end
      end
   end

   // main sequence
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_beat(directed_rows[i].op, directed_rows[i].value, directed_rows[i].has_exp,
                   directed_rows[i].exp_snapped, directed_rows[i].exp_status);

      run_phase(0, 1'b0);
      run_phase(65, 1'b0);
      run_phase(0, 1'b1);
      run_phase(24, 1'b0);

      start <= 1'b0;
      while (pending_snaps.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (mismatch_cnt == 0 && pending_snaps.size() == 0)
         $display("nearest_onset_snap_top_test passed");
      else
         $display("nearest_onset_snap_top_test failed");
      $finish;
   end

endmodule

FILE: filelist.f
src/nos_pkg.sv
src/nos_table.sv
src/nearest_onset_snap_top.sv
verif/nearest_onset_snap_top_test.sv
